FILE: rtl/core/lru_recency_ring_top_defines.svh
// ----------------------------------------------------------------------------
// lru_recency_ring_top_defines
// Assertion macros for the recency ring top.
// ----------------------------------------------------------------------------
`ifndef LRU_RECENCY_RING_TOP_DEFINES_SVH
`define LRU_RECENCY_RING_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LRR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lrr: same-cycle check failed");
// next-cycle implication
`define LRR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lrr: next-cycle check failed");
`else
`define LRR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LRR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/core/lrr_pkg.sv
// ----------------------------------------------------------------------------
// lrr_pkg
// Shared constants and types of the recency ring.
// ----------------------------------------------------------------------------
package lrr_pkg;

   localparam int EntryW = 6;

   localparam logic ACT_TOUCH  = 1'b0;
   localparam logic ACT_VICTIM = 1'b1;

   typedef struct packed {
      logic compare;
      logic apply;
   } cell_ctl_type;

endpackage

FILE: rtl/core/lrr_req_if.sv
// ----------------------------------------------------------------------------
// lrr_req_if
// Request channel: action and entry index, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lrr_req_if;
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [lrr_pkg::EntryW-1:0]  entry;

   modport source (output valid, output action, output entry, input ready);
   modport sink   (input valid, input action, input entry, output ready);
endinterface

FILE: rtl/core/lrr_rsp_if.sv
// ----------------------------------------------------------------------------
// lrr_rsp_if
// Response channel: victim index, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lrr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lrr_pkg::EntryW-1:0]  victim;

   modport source (output valid, output victim, input ready);
   modport sink   (input valid, input victim, output ready);
endinterface

FILE: rtl/core/lrr_cell.sv
// ----------------------------------------------------------------------------
// lrr_cell
// One position of the recency order: holds an entry index, compares it with
// the broadcast key and takes its neighbour's index on a shift.
// ----------------------------------------------------------------------------
module lrr_cell #(
   parameter int IdxW     = 6,
   parameter int CmpW     = 6,
   parameter int ResetVal = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lrr_pkg::cell_ctl_type ctl,
   input  logic [CmpW-1:0]       key,
   input  logic [IdxW-1:0]       shift_in,
   input  logic                  shift_en,
   output logic [IdxW-1:0]       value,
   output logic                  match
);

   logic [IdxW-1:0] value_ff, value_in;
   logic            match_ff, match_in;

   always_comb begin
      value_in = value_ff;
      match_in = match_ff;
      if (ctl.compare) begin
         match_in = (CmpW'(value_ff) == key);
      end
      if (ctl.apply && shift_en) begin
         value_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= IdxW'(ResetVal);
         match_ff <= 1'b0;
      end else begin
         value_ff <= value_in;
         match_ff <= match_in;
      end
   end

   assign value = value_ff;
   assign match = match_ff;

endmodule

FILE: rtl/core/lrr_ctrl.sv
// ----------------------------------------------------------------------------
// lrr_ctrl
// Sequencer of the recency ring: accepts items, drives the compare and shift
// phases of the cell row and holds victim items for the response side.
// ----------------------------------------------------------------------------
module lrr_ctrl #(
   parameter int IdxW = 6,
   parameter int CmpW = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   lrr_req_if.sink                req_ch,
   lrr_rsp_if.source              rsp_ch,
   input  logic [IdxW-1:0]        last_value,
   output lrr_pkg::cell_ctl_type  ctl,
   output logic [CmpW-1:0]        key,
   output logic [IdxW-1:0]        ins_value
);

   typedef enum logic {
      ST_IDLE,
      ST_APPLY
   } state_type;

   state_type                   state_ff, state_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [lrr_pkg::EntryW-1:0]  rsp_victim_ff, rsp_victim_in;
   logic                        spare_valid_ff, spare_valid_in;
   logic [lrr_pkg::EntryW-1:0]  spare_victim_ff, spare_victim_in;
   logic [CmpW-1:0]             key_ff, key_in;
   logic [CmpW-1:0]             last_ext;
   logic                        accept;
   logic                        is_victim;
   logic                        push;
   logic                        pop;

   assign last_ext   = CmpW'(last_value);
   assign is_victim  = (req_ch.action == lrr_pkg::ACT_VICTIM);
   assign req_ch.ready = (state_ff == ST_IDLE) && !spare_valid_ff;
   assign accept     = req_ch.valid && req_ch.ready;
   assign key        = is_victim ? last_ext : CmpW'(req_ch.entry);
   assign push       = accept && is_victim;
   assign pop        = rsp_valid_ff && rsp_ch.ready;

   always_comb begin
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_victim_in   = rsp_victim_ff;
      spare_valid_in  = spare_valid_ff;
      spare_victim_in = spare_victim_ff;
      key_in          = key_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (pop) begin
         rsp_valid_in   = spare_valid_ff;
         rsp_victim_in  = spare_victim_ff;
         spare_valid_in = 1'b0;
      end
      if (accept) begin
         key_in = key;
      end
      if (push) begin
         if (!rsp_valid_in) begin
            rsp_valid_in  = 1'b1;
            rsp_victim_in = last_ext[lrr_pkg::EntryW-1:0];
         end else begin
            spare_valid_in  = 1'b1;
            spare_victim_in = last_ext[lrr_pkg::EntryW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
      rsp_victim_ff   <= rsp_victim_in;
      spare_victim_ff <= spare_victim_in;
      key_ff          <= key_in;
   end

   assign ctl.compare   = accept;
   assign ctl.apply     = (state_ff == ST_APPLY);
   assign ins_value     = key_ff[IdxW-1:0];
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.victim = rsp_victim_ff;

endmodule

FILE: rtl/core/lru_recency_ring_top.sv
// Least-recently-used order over ENTRIES entry indices, kept as a row of
// cells ordered newest first. A touch moves its entry to the front; a victim
// request returns the last (oldest) entry and moves it to the front, giving
// one response item; a touch of an index at or above ENTRIES is dropped.
// Each item has a compare phase, matching the key against every cell, and
// an apply phase, shifting the cells up to the hit position by one place;
// no item is taken in the apply phase. Victims wait in a two-place response
// buffer; requests also stall while it is full. Reset order: 0..ENTRIES-1.
// ----------------------------------------------------------------------------
// lru_recency_ring_top
// Recency ring built as a shifting row of compare cells.
// ----------------------------------------------------------------------------
`include "lru_recency_ring_top_defines.svh"

module lru_recency_ring_top #(
   parameter int ENTRIES = 64
) (
   input  logic       clock,
   input  logic       reset,
   lrr_req_if.sink    req_ch,
   lrr_rsp_if.source  rsp_ch
);

   localparam int IdxW = $clog2(ENTRIES);
   localparam int CmpW = (IdxW > lrr_pkg::EntryW) ? IdxW : lrr_pkg::EntryW;

   lrr_pkg::cell_ctl_type  ctl;
   logic [CmpW-1:0]        key;
   logic [IdxW-1:0]        ins_value;
   logic [IdxW-1:0]        cell_value [ENTRIES];
   logic [ENTRIES-1:0]     match;
   logic [ENTRIES-1:0]     shift_en;

   lrr_ctrl #(
      .IdxW (IdxW),
      .CmpW (CmpW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .last_value (cell_value[ENTRIES-1]),
      .ctl        (ctl),
      .key        (key),
      .ins_value  (ins_value)
   );

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic [IdxW-1:0] shift_in;

      if (i == 0) begin : g_head
         assign shift_in = ins_value;
      end else begin : g_body
         assign shift_in = cell_value[i-1];
      end

      // shift every cell at or before the hit position
      assign shift_en[i] = |match[ENTRIES-1:i];

      lrr_cell #(
         .IdxW     (IdxW),
         .CmpW     (CmpW),
         .ResetVal (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .key      (key),
         .shift_in (shift_in),
         .shift_en (shift_en[i]),
         .value    (cell_value[i]),
         .match    (match[i])
      );
   end

   `LRR_ASSERT_IMPL(a_match_unique, clock, reset, 1'b1, $onehot0(match))
   `LRR_ASSERT_NEXT(a_victim_hits_tail, clock, reset,
      req_ch.valid && req_ch.ready && (req_ch.action == lrr_pkg::ACT_VICTIM),
      match[ENTRIES-1] && $onehot(match))
   `LRR_ASSERT_NEXT(a_accept_then_apply, clock, reset,
      req_ch.valid && req_ch.ready, ctl.apply && !req_ch.ready)

endmodule

FILE: bench/tb_lru_recency_ring_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_recency_ring_top
// Self-checking bench for the recency ring. A shadow ring of next/prev links
// and a newest pointer predicts each victim item. Touches of the newest, the
// oldest and a middle entry are steered from a generation-time copy of that
// ring. Both channels stall in random bursts. Before a drain-marked item the
// sender waits until the response queue is empty.
// ----------------------------------------------------------------------------
module tb_lru_recency_ring_top;

   localparam int EntryW        = lrr_pkg::EntryW;
   localparam int NUM_ENTRIES   = 64;
   localparam int RANDOM_ITEMS  = 1450;
   localparam int CALM_ITEMS    = 150;
   localparam int SETTLE_CYCLES = 20;
   localparam int STALL_LIMIT   = 1000;

   typedef struct packed {
      logic [EntryW-1:0]                  head;
      logic [NUM_ENTRIES-1:0][EntryW-1:0] nxt;
      logic [NUM_ENTRIES-1:0][EntryW-1:0] prv;
   } ring_type;

   typedef enum logic [1:0] {
      MV_VICTIM,
      MV_NEWEST,
      MV_OLDEST,
      MV_RELINK
   } move_type;

   typedef struct packed {
      logic              action;
      logic [EntryW-1:0] entry;
      logic              drain;
   } lookup_type;

   logic clock;
   logic reset;

   lrr_req_if req_bus ();
   lrr_rsp_if rsp_bus ();

   lru_recency_ring_top #(
      .ENTRIES (NUM_ENTRIES)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   lookup_type        lookup_queue [$];
   logic [EntryW-1:0] victim_queue [$];

   ring_type shadow_ring;
   ring_type gen_ring;

   int  total_items;
   int  sent_count;
   int  err_count;
   int  victim_count;
   int  newest_count;
   int  oldest_count;
   int  relink_count;
   int  drain_count;
   int  idle_cycles;
   int  req_gap;
   int  rsp_gap;
   bit  req_fire;
   bit  rsp_fire;
   bit  drv_busy;

   function automatic ring_type ring_reset();
      ring_type r;
      r.head = '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         r.nxt[i] = EntryW'((i + 1) % NUM_ENTRIES);
         r.prv[i] = EntryW'((i + NUM_ENTRIES - 1) % NUM_ENTRIES);
      end
      return r;
   endfunction

   function automatic move_type ring_step(inout ring_type r, input logic act,
                                          input logic [EntryW-1:0] ent,
                                          output logic [EntryW-1:0] victim);
      logic [EntryW-1:0] head;
      logic [EntryW-1:0] oldest;
      logic [EntryW-1:0] bef;
      logic [EntryW-1:0] aft;
      head   = r.head;
      oldest = r.prv[head];
      victim = oldest;
      if (act == lrr_pkg::ACT_VICTIM) begin
         r.head = oldest;
         return MV_VICTIM;
      end
      if (ent == head)
         return MV_NEWEST;
      if (ent == oldest) begin
         r.head = ent;
         return MV_OLDEST;
      end
      // unlink, then relink just before the newest entry
      bef = r.prv[ent];
      aft = r.nxt[ent];
      r.nxt[bef] = aft;
      r.prv[aft] = bef;
      bef = r.prv[head];
      r.nxt[bef] = ent;
      r.prv[head] = ent;
      r.nxt[ent] = head;
      r.prv[ent] = bef;
      r.head = ent;
      return MV_RELINK;
   endfunction

   task automatic queue_lookup(input logic act, input logic [EntryW-1:0] ent,
                               input logic drain);
      lookup_type        item;
      logic [EntryW-1:0] unused_victim;
      move_type          unused_move;
      item.action = act;
      item.entry  = ent;
      item.drain  = drain;
      lookup_queue.push_back(item);
      unused_move = ring_step(gen_ring, act, ent, unused_victim);
   endtask

   task automatic report_mismatch(input string what, input logic [EntryW-1:0] got,
                                  input logic [EntryW-1:0] want);
      $display("[%0t] mismatch: %s got %0d want %0d", $time, what, got, want);
      err_count++;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.action  = lrr_pkg::ACT_TOUCH;
      req_bus.entry   = '0;
      rsp_bus.ready   = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // driver: present items on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         drv_busy = 1'b0;
      end else if (!drv_busy || req_fire) begin
         if (lookup_queue.size() == 0) begin
            req_bus.valid <= 1'b0;
            drv_busy = 1'b0;
         end else if (req_gap > 0) begin
            req_bus.valid <= 1'b0;
            drv_busy = 1'b0;
            req_gap--;
         end else if (lookup_queue[0].drain && victim_queue.size() != 0) begin
            req_bus.valid <= 1'b0;
            drv_busy = 1'b0;
         end else begin
            lookup_type item;
            item = lookup_queue.pop_front();
            if (item.drain)
               drain_count++;
            req_bus.valid  <= 1'b1;
            req_bus.action <= item.action;
            req_bus.entry  <= item.entry;
            drv_busy = 1'b1;
            sent_count++;
            if (sent_count < total_items - CALM_ITEMS && $urandom_range(0, 3) == 0)
               req_gap = $urandom_range(1, 3);
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap--;
      end else if (sent_count < total_items - CALM_ITEMS && $urandom_range(0, 4) == 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap = $urandom_range(0, 2);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      req_fire = !reset && req_bus.valid && req_bus.ready;
      rsp_fire = !reset && rsp_bus.valid && rsp_bus.ready;
      if (req_fire) begin
         logic [EntryW-1:0] victim;
         move_type          mv;
         mv = ring_step(shadow_ring, req_bus.action, req_bus.entry, victim);
         case (mv)
            MV_VICTIM: begin
               victim_queue.push_back(victim);
               victim_count++;
            end
            MV_NEWEST: newest_count++;
            MV_OLDEST: oldest_count++;
            default:   relink_count++;
         endcase
      end
      if (rsp_fire) begin
         if (victim_queue.size() == 0) begin
            report_mismatch("unexpected victim item", rsp_bus.victim, '0);
         end else begin
            logic [EntryW-1:0] want;
            want = victim_queue.pop_front();
            if (rsp_bus.victim !== want)
               report_mismatch("victim", rsp_bus.victim, want);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || req_fire || rsp_fire)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[%0t] no progress for %0d cycles, %0d victims outstanding",
                  $time, STALL_LIMIT, victim_queue.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int pick;
      shadow_ring = ring_reset();
      gen_ring    = ring_reset();
      err_count = 0; sent_count = 0; victim_count = 0; newest_count = 0;
      oldest_count = 0; relink_count = 0; drain_count = 0;
      idle_cycles = 0; req_gap = 0; rsp_gap = 0;
      req_fire = 1'b0; rsp_fire = 1'b0; drv_busy = 1'b0;

      // directed: newest, oldest, middle, extremes of the index
      queue_lookup(lrr_pkg::ACT_TOUCH,  6'd0,  1'b0);
      queue_lookup(lrr_pkg::ACT_TOUCH,  6'd63, 1'b0);
      queue_lookup(lrr_pkg::ACT_VICTIM, 6'd0,  1'b0);
      queue_lookup(lrr_pkg::ACT_VICTIM, 6'd63, 1'b0);
      queue_lookup(lrr_pkg::ACT_TOUCH,  6'd5,  1'b0);
      queue_lookup(lrr_pkg::ACT_TOUCH,  6'd5,  1'b0);
      queue_lookup(lrr_pkg::ACT_TOUCH,  6'd32, 1'b0);
      queue_lookup(lrr_pkg::ACT_TOUCH,  6'd1,  1'b0);
      queue_lookup(lrr_pkg::ACT_VICTIM, 6'd21, 1'b0);
      queue_lookup(lrr_pkg::ACT_VICTIM, 6'd42, 1'b0);
      queue_lookup(lrr_pkg::ACT_TOUCH,  6'd63, 1'b1);
      queue_lookup(lrr_pkg::ACT_TOUCH,  6'd0,  1'b0);
      queue_lookup(lrr_pkg::ACT_TOUCH,  6'd62, 1'b0);
      queue_lookup(lrr_pkg::ACT_TOUCH,  gen_ring.prv[gen_ring.head], 1'b0);
      queue_lookup(lrr_pkg::ACT_VICTIM, 6'd0,  1'b0);
      queue_lookup(lrr_pkg::ACT_TOUCH,  gen_ring.head, 1'b0);
      queue_lookup(lrr_pkg::ACT_TOUCH,  gen_ring.nxt[gen_ring.head], 1'b0);
      for (int i = 0; i < 4; i++)
         queue_lookup(lrr_pkg::ACT_VICTIM, 6'(i * 21), 1'b0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         logic drain;
         drain = ($urandom_range(0, 199) == 0);
         pick  = $urandom_range(0, 99);
         if (pick < 30)
            queue_lookup(lrr_pkg::ACT_VICTIM, 6'($urandom), drain);
         else if (pick < 42)
            queue_lookup(lrr_pkg::ACT_TOUCH, gen_ring.head, drain);
         else if (pick < 57)
            queue_lookup(lrr_pkg::ACT_TOUCH, gen_ring.prv[gen_ring.head], drain);
         else if (pick < 67)
            queue_lookup(lrr_pkg::ACT_TOUCH, gen_ring.nxt[gen_ring.head], drain);
         else
            queue_lookup(lrr_pkg::ACT_TOUCH, 6'($urandom), drain);
      end
      total_items = lookup_queue.size();

      @(negedge reset);
      do @(posedge clock);
      while (lookup_queue.size() != 0 || drv_busy || victim_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("items %0d: victims %0d, touches of newest %0d, of oldest %0d, relinks %0d",
               sent_count, victim_count, newest_count, oldest_count, relink_count);
      $display("drain pauses %0d, mismatches %0d", drain_count, err_count);
      if (err_count == 0 && victim_queue.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
